FILE: design/bntt_pkg.sv
// Shared types and character constants for the decimal number to text block.
package bntt_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_NORM,
        S_PLAN,
        S_CHECK,
        S_EMIT
    } t_state;

    // Text sections in output order
    typedef enum logic [3:0] {
        SEC_SIGN,
        SEC_INT,
        SEC_PAD,
        SEC_POINT,
        SEC_FRAC,
        SEC_E,
        SEC_ESIGN,
        SEC_EH,
        SEC_ET,
        SEC_EO,
        SEC_NUL
    } t_sec;

    localparam int SEC_COUNT = 11;

    localparam int CHAR_W = 8;
    localparam int EXP_IN_W = 8;
    localparam int EXP_W = 9;
    localparam int ROOM_W = 8;
    localparam int SIZE_W = 5;
    localparam int MAG_W = 8;

    localparam logic [CHAR_W-1:0] CH_NUL = 8'h00;
    localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_E = 8'h65;

    // Plain notation window for the adjusted exponent
    localparam logic signed [EXP_W-1:0] WIN_LO = 9'sd1;
    localparam logic signed [EXP_W-1:0] WIN_HI = 9'sd5;

    localparam logic [MAG_W-1:0] MAG_HUND = 8'd100;
    localparam logic [MAG_W-1:0] MAG_TEN = 8'd10;

endpackage

FILE: design/bcd_number_to_text.sv
// Top level: decimal number to ASCII text, one character per output beat.
// Flow: after the input beat come the scan, plan and room check states, then one
// character per cycle into the output register while it is free.
// Each item yields N characters (N up to 23), or a single report beat when the room is
// too small; a new item is taken only back in idle, and output stalls stretch the loop.
// Reset: synchronous, active low; idles the sequencer and empties the output register.
module bcd_number_to_text #(
    parameter int MANTISSA_DIGITS = 15
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic [4*MANTISSA_DIGITS-1:0]          i_mantissa_digits,
    input  logic signed [bntt_pkg::EXP_IN_W-1:0]  i_exponent_value,
    input  logic                                  i_is_negative,
    input  logic [bntt_pkg::ROOM_W-1:0]           i_buffer_room,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic [bntt_pkg::CHAR_W-1:0]           o_char_code,
    output logic                                  o_last_of_run,
    output logic                                  o_fits,
    output logic [bntt_pkg::SIZE_W-1:0]           o_needed_size
);
    import bntt_pkg::*;

    localparam int IW = (MANTISSA_DIGITS > 1) ? $clog2(MANTISSA_DIGITS) : 1;
    localparam int LW = $clog2(MANTISSA_DIGITS + 1);

    t_state r_state, n_state;

    // input beat
    logic [4*MANTISSA_DIGITS-1:0] r_dig;
    logic [EXP_IN_W-1:0]          r_e0;
    logic                         r_neg;
    logic [ROOM_W-1:0]            r_room;

    // scan results
    logic [IW-1:0]            r_first;
    logic [LW-1:0]            r_len;
    logic signed [EXP_W-1:0]  r_ex;

    // layout
    logic [2:0]        r_ints;
    logic [2:0]        r_pad;
    logic              r_frac;
    logic              r_expo;
    logic              r_sneg;
    logic [MAG_W-1:0]  r_mag;
    logic [SIZE_W-1:0] r_size;
    logic              r_eh;
    logic [3:0]        r_et;
    logic [3:0]        r_eo;

    // character sequencer
    t_sec          r_sec;
    logic [LW-1:0] r_k;
    logic [2:0]    r_p;

    // output register
    logic              r_out_valid;
    logic [CHAR_W-1:0] r_char;
    logic              r_last;
    logic              r_fits;
    logic [SIZE_W-1:0] r_need;

    logic [CHAR_W-1:0] n_char;
    logic              n_last;
    logic              n_fits;
    logic [SIZE_W-1:0] n_need;

    logic [IW-1:0] w_first;
    logic [LW-1:0] w_len;
    logic          w_zero;

    bntt_norm #(
        .MANTISSA_DIGITS(MANTISSA_DIGITS)
    ) u_norm (
        .i_digits (r_dig),
        .o_first  (w_first),
        .o_len    (w_len),
        .o_zero   (w_zero)
    );

    // ---------------- plan arithmetic ----------------
    logic signed [EXP_W-1:0] w_ex;
    logic                    w_win;
    logic [2:0]              w_ints;
    logic signed [EXP_W-1:0] w_shown;
    logic [5:0]              w_len6;
    logic [5:0]              w_ints6;
    logic [2:0]              w_pad;
    logic                    w_frac;
    logic                    w_sneg;
    logic [EXP_W-1:0]        w_neg_shown;
    logic [MAG_W-1:0]        w_mag;
    logic [5:0]              w_ndig;
    logic [5:0]              w_size;

    assign w_ex = w_zero ? WIN_LO
                         : $signed({r_e0[EXP_IN_W-1], r_e0}) - $signed(EXP_W'(w_first));

    assign w_win   = (r_ex >= WIN_LO) && (r_ex <= WIN_HI);
    assign w_ints  = w_win ? r_ex[2:0] : 3'd1;
    assign w_shown = w_win ? '0 : r_ex - WIN_LO;
    assign w_len6  = 6'(r_len);
    assign w_ints6 = 6'(w_ints);
    assign w_pad   = (w_ints6 > w_len6) ? 3'(w_ints6 - w_len6) : 3'd0;
    assign w_frac  = (w_len6 > w_ints6);
    assign w_sneg  = w_shown[EXP_W-1];
    assign w_neg_shown = -w_shown;
    assign w_mag   = w_sneg ? w_neg_shown[MAG_W-1:0] : w_shown[MAG_W-1:0];
    assign w_ndig  = (w_mag >= MAG_HUND) ? 6'd3 : (w_mag >= MAG_TEN) ? 6'd2 : 6'd1;
    assign w_size  = 6'(r_neg) + w_len6 + 6'(w_pad) + 6'(w_frac) + 6'd1
                   + ((w_shown != '0) ? (6'd1 + 6'(w_sneg) + w_ndig) : 6'd0);

    // ---------------- exponent digits ----------------
    logic [6:0]  w_rem;
    logic [17:0] w_prod;
    logic [3:0]  w_tens;
    logic [6:0]  w_tens10;
    logic [6:0]  w_ones;

    assign w_rem    = (r_mag >= MAG_HUND) ? 7'(r_mag - MAG_HUND) : r_mag[6:0];
    // divide by ten through the reciprocal 205/2048, exact below 100
    assign w_prod   = 18'(w_rem) * 18'd205;
    assign w_tens   = w_prod[14:11];
    assign w_tens10 = 7'({w_tens, 3'b000}) + 7'({w_tens, 1'b0});
    assign w_ones   = w_rem - w_tens10;

    // ---------------- sequencer helpers ----------------
    logic [SEC_COUNT-1:0] w_en;
    logic [LW-1:0]        w_nint;
    logic [LW:0]          w_idx_sum;
    logic [IW-1:0]        w_idx;
    logic [3:0]           w_nib [MANTISSA_DIGITS];
    logic [CHAR_W-1:0]    w_dchar;
    logic                 w_slot;
    logic                 w_fits;
    logic                 w_adv;
    logic                 w_k_inc;
    logic                 w_p_inc;
    logic                 w_load;
    t_sec                 w_nsec;

    for (genvar g = 0; g < MANTISSA_DIGITS; g++) begin : g_nib
        assign w_nib[g] = r_dig[4*(MANTISSA_DIGITS-1-g) +: 4];
    end

    assign w_en = {1'b1,                              // NUL
                   r_expo,                            // ones
                   r_expo && (r_mag >= MAG_TEN),      // tens
                   r_expo && (r_mag >= MAG_HUND),     // hundreds
                   r_expo && r_sneg,                  // exponent sign
                   r_expo,                            // 'e'
                   r_frac,                            // fraction
                   r_frac,                            // point
                   (r_pad != 3'd0),                   // padding
                   1'b1,                              // integer digits
                   r_neg};                            // sign

    function automatic t_sec next_sec(input t_sec cur, input logic [SEC_COUNT-1:0] en);
        t_sec nxt;
        nxt = SEC_NUL;
        for (int j = SEC_COUNT - 1; j >= 0; j--) begin
            if (en[j] && (j > int'(cur))) begin
                nxt = t_sec'(4'(j));
            end
        end
        return nxt;
    endfunction

    assign w_nsec    = next_sec(r_sec, w_en);
    assign w_nint    = (6'(r_len) < 6'(r_ints)) ? r_len : LW'(r_ints);
    assign w_idx_sum = (LW+1)'(r_first) + (LW+1)'(r_k);
    assign w_idx     = w_idx_sum[IW-1:0];
    assign w_dchar   = CH_ZERO + CHAR_W'(w_nib[w_idx]);
    assign w_slot    = ~r_out_valid | i_ready;
    assign w_fits    = ({{(ROOM_W-SIZE_W){1'b0}}, r_size} <= r_room);

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_valid) n_state = S_NORM;
            S_NORM:  n_state = S_PLAN;
            S_PLAN:  n_state = S_CHECK;
            S_CHECK: begin
                if (w_fits) begin
                    n_state = S_EMIT;
                end else if (w_slot) begin
                    n_state = S_IDLE;
                end
            end
            S_EMIT:  if (w_slot && (r_sec == SEC_NUL)) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // ---------------- outputs of the sequencer ----------------
    always_comb begin
        w_load  = 1'b0;
        w_adv   = 1'b0;
        w_k_inc = 1'b0;
        w_p_inc = 1'b0;
        n_char  = CH_NUL;
        n_last  = 1'b0;
        n_fits  = 1'b1;
        n_need  = '0;
        case (r_state)
            S_CHECK: begin
                if (!w_fits && w_slot) begin
                    w_load = 1'b1;
                    n_last = 1'b1;
                    n_fits = 1'b0;
                    n_need = r_size;
                end
            end
            S_EMIT: begin
                if (w_slot) begin
                    w_load = 1'b1;
                    case (r_sec)
                        SEC_SIGN: begin
                            n_char = CH_MINUS;
                            w_adv  = 1'b1;
                        end
                        SEC_INT: begin
                            n_char  = w_dchar;
                            w_k_inc = 1'b1;
                            w_adv   = ((LW+1)'(r_k) + (LW+1)'(1) == (LW+1)'(w_nint));
                        end
                        SEC_PAD: begin
                            n_char  = CH_ZERO;
                            w_p_inc = 1'b1;
                            w_adv   = (r_p + 3'd1 == r_pad);
                        end
                        SEC_POINT: begin
                            n_char = CH_POINT;
                            w_adv  = 1'b1;
                        end
                        SEC_FRAC: begin
                            n_char  = w_dchar;
                            w_k_inc = 1'b1;
                            w_adv   = ((LW+1)'(r_k) + (LW+1)'(1) == (LW+1)'(r_len));
                        end
                        SEC_E: begin
                            n_char = CH_E;
                            w_adv  = 1'b1;
                        end
                        SEC_ESIGN: begin
                            n_char = CH_MINUS;
                            w_adv  = 1'b1;
                        end
                        SEC_EH: begin
                            n_char = CH_ZERO + CHAR_W'(r_eh);
                            w_adv  = 1'b1;
                        end
                        SEC_ET: begin
                            n_char = CH_ZERO + CHAR_W'(r_et);
                            w_adv  = 1'b1;
                        end
                        SEC_EO: begin
                            n_char = CH_ZERO + CHAR_W'(r_eo);
                            w_adv  = 1'b1;
                        end
                        SEC_NUL: begin
                            n_char = CH_NUL;
                            n_last = 1'b1;
                        end
                        default: begin
                            n_char = CH_NUL;
                            n_last = 1'b1;
                        end
                    endcase
                end
            end
            default: begin
                w_load = 1'b0;
            end
        endcase
    end

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    r_dig  <= i_mantissa_digits;
                    r_e0   <= i_exponent_value;
                    r_neg  <= i_is_negative;
                    r_room <= i_buffer_room;
                end
            end
            S_NORM: begin
                r_first <= w_first;
                r_len   <= w_len;
                r_ex    <= w_ex;
                // zero prints without a sign
                r_neg   <= r_neg & ~w_zero;
            end
            S_PLAN: begin
                r_ints <= w_ints;
                r_pad  <= w_pad;
                r_frac <= w_frac;
                r_expo <= (w_shown != '0);
                r_sneg <= w_sneg;
                r_mag  <= w_mag;
                r_size <= w_size[SIZE_W-1:0];
            end
            S_CHECK: begin
                r_eh  <= (r_mag >= MAG_HUND);
                r_et  <= w_tens;
                r_eo  <= w_ones[3:0];
                r_sec <= r_neg ? SEC_SIGN : SEC_INT;
                r_k   <= '0;
                r_p   <= '0;
            end
            S_EMIT: begin
                if (w_k_inc) r_k <= r_k + LW'(1);
                if (w_p_inc) r_p <= r_p + 3'd1;
                if (w_adv) r_sec <= w_nsec;
            end
            default: begin
                r_k <= r_k;
            end
        endcase
        if (w_load) begin
            r_char <= n_char;
            r_last <= n_last;
            r_fits <= n_fits;
            r_need <= n_need;
        end
    end

    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = r_out_valid;
    assign o_char_code   = r_char;
    assign o_last_of_run = r_last;
    assign o_fits        = r_fits;
    assign o_needed_size = r_need;

    // ---------------- assertions ----------------
    a_short_is_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_fits) |-> (o_last_of_run && (o_char_code == CH_NUL)))
        else $error("room report is not a single terminating beat");

    a_last_is_nul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_of_run) |-> (o_char_code == CH_NUL))
        else $error("final beat is not the terminator");

    a_frac_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_EMIT) && ((r_sec == SEC_FRAC) || (r_sec == SEC_INT)))
            |-> ((LW+1)'(r_k) < (LW+1)'(r_len)))
        else $error("digit counter ran past the significant digits");

    a_busy_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) && !(w_slot && (r_sec == SEC_NUL)) |=> !o_ready)
        else $error("input taken while text still in progress");

endmodule

FILE: design/bntt_norm.sv
// Digit scan: position of the first nonzero digit and length of the significant run.
module bntt_norm #(
    parameter int MANTISSA_DIGITS = 15
) (
    input  logic [4*MANTISSA_DIGITS-1:0]                       i_digits,
    output logic [((MANTISSA_DIGITS > 1) ? $clog2(MANTISSA_DIGITS) : 1)-1:0] o_first,
    output logic [$clog2(MANTISSA_DIGITS+1)-1:0]               o_len,
    output logic                                               o_zero
);
    localparam int IW = (MANTISSA_DIGITS > 1) ? $clog2(MANTISSA_DIGITS) : 1;
    localparam int LW = $clog2(MANTISSA_DIGITS + 1);

    logic [IW-1:0] w_first;
    logic [IW-1:0] w_last;
    logic          w_any;
    logic [LW:0]   w_span;

    always_comb begin
        w_first = '0;
        w_last  = '0;
        w_any   = 1'b0;
        // downward pass keeps the lowest index, upward pass the highest
        for (int i = MANTISSA_DIGITS - 1; i >= 0; i--) begin
            if (i_digits[4*(MANTISSA_DIGITS-1-i) +: 4] != 4'd0) begin
                w_first = IW'(i);
                w_any   = 1'b1;
            end
        end
        for (int i = 0; i < MANTISSA_DIGITS; i++) begin
            if (i_digits[4*(MANTISSA_DIGITS-1-i) +: 4] != 4'd0) begin
                w_last = IW'(i);
            end
        end
    end

    assign w_span  = (LW+1)'(w_last) - (LW+1)'(w_first) + (LW+1)'(1);
    // all-zero mantissa reads as the single digit zero
    assign o_first = w_any ? w_first : '0;
    assign o_len   = w_any ? w_span[LW-1:0] : LW'(1);
    assign o_zero  = ~w_any;

endmodule
